// ===== hdl/upc_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 preview collapse package
// Shared types, byte codes and decode helpers for the preview core.
// ----------------------------------------------------------------------------
`default_nettype none

package upc_pkg;

    localparam logic [7:0]  SPACE_BYTE  = 8'h20;
    localparam logic [7:0]  DEL_BYTE    = 8'h7F;
    localparam logic [7:0]  ASCII_TOP   = 8'h80;
    localparam logic [7:0]  MASK_LEAD2  = 8'hE0;
    localparam logic [7:0]  CODE_LEAD2  = 8'hC0;
    localparam logic [7:0]  MASK_LEAD3  = 8'hF0;
    localparam logic [7:0]  CODE_LEAD3  = 8'hE0;
    localparam logic [15:0] LIMIT_RESET = 16'd100;

    // Work handed from the front to the back: up to four bytes and an end mark.
    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] bytes;
        logic            done;
    } t_job;

    typedef enum logic [1:0] {
        BYTE_WS,
        BYTE_CTRL,
        BYTE_CHAR
    } t_byte_class;

    function automatic logic [2:0] seq_len(input logic [7:0] c);
        logic [2:0] len;
        if (c < ASCII_TOP) begin
            len = 3'd1;
        end else if ((c & MASK_LEAD2) == CODE_LEAD2) begin
            len = 3'd2;
        end else if ((c & MASK_LEAD3) == CODE_LEAD3) begin
            len = 3'd3;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    function automatic t_byte_class classify(input logic [7:0] c);
        t_byte_class cls;
        case (c) inside
            SPACE_BYTE, [8'h09:8'h0D]: cls = BYTE_WS;
            [8'h00:8'h1F], DEL_BYTE:   cls = BYTE_CTRL;
            default:                   cls = BYTE_CHAR;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/upc_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 preview collapse front end
// Classifies bytes, tracks per-text state and builds at most one job per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module upc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_wdata,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_text_byte,
    input  wire logic          i_text_last,
    output logic               o_job_valid,
    output upc_pkg::t_job      o_job
);

    logic [15:0] r_char_limit;
    logic [15:0] r_char_count, n_char_count;
    logic        r_space_pending, n_space_pending;
    logic        r_any_emitted, n_any_emitted;
    logic        r_limit_reached, n_limit_reached;
    logic [2:0]  r_seq_total, n_seq_total;
    logic [2:0]  r_seq_have, n_seq_have;
    logic [7:0]  r_seq_bytes [3];
    logic        seq_wr;

    logic [16:0] count_inc;
    logic [2:0]  lead_len;
    upc_pkg::t_job job;

    assign count_inc = {1'b0, r_char_count} + 17'd1;
    assign lead_len  = upc_pkg::seq_len(i_text_byte);

    always_comb begin
        n_char_count    = r_char_count;
        n_space_pending = r_space_pending;
        n_any_emitted   = r_any_emitted;
        n_limit_reached = r_limit_reached;
        n_seq_total     = r_seq_total;
        n_seq_have      = r_seq_have;
        seq_wr          = 1'b0;
        job.n           = 3'd0;
        job.bytes       = '0;
        job.done        = i_text_last;

        if (r_seq_total != 3'd0) begin
            if (r_seq_have + 3'd1 >= r_seq_total) begin
                job.n = r_seq_total;
                for (int j = 0; j < 3; j++) begin
                    job.bytes[j] = (r_seq_have == 3'(j)) ? i_text_byte : r_seq_bytes[j];
                end
                job.bytes[3]  = i_text_byte;
                n_char_count  = r_char_count + 16'd1;
                n_any_emitted = 1'b1;
                n_seq_total   = 3'd0;
                n_seq_have    = 3'd0;
            end else begin
                seq_wr     = 1'b1;
                n_seq_have = r_seq_have + 3'd1;
            end
        end else if (!r_limit_reached && (r_char_count >= r_char_limit)) begin
            n_limit_reached = 1'b1;
        end else if (!r_limit_reached) begin
            case (upc_pkg::classify(i_text_byte))
                upc_pkg::BYTE_WS: begin
                    n_space_pending = r_any_emitted;
                end
                upc_pkg::BYTE_CHAR: begin
                    if (r_space_pending && (count_inc >= {1'b0, r_char_limit})) begin
                        n_limit_reached = 1'b1;
                    end else begin
                        if (r_space_pending) begin
                            job.n           = 3'd1;
                            job.bytes[0]    = upc_pkg::SPACE_BYTE;
                            n_char_count    = r_char_count + 16'd1;
                            n_space_pending = 1'b0;
                            n_any_emitted   = 1'b1;
                        end
                        if (lead_len == 3'd1) begin
                            if (r_space_pending) begin
                                job.bytes[1] = i_text_byte;
                            end else begin
                                job.bytes[0] = i_text_byte;
                            end
                            job.n         = job.n + 3'd1;
                            n_char_count  = n_char_count + 16'd1;
                            n_any_emitted = 1'b1;
                        end else begin
                            seq_wr      = 1'b1;
                            n_seq_have  = 3'd1;
                            n_seq_total = lead_len;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_text_last) begin
            n_char_count    = '0;
            n_space_pending = 1'b0;
            n_any_emitted   = 1'b0;
            n_limit_reached = 1'b0;
            n_seq_total     = 3'd0;
            n_seq_have      = 3'd0;
        end
    end

    assign o_job_valid = i_accept && ((job.n != 3'd0) || job.done);
    assign o_job       = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_limit    <= upc_pkg::LIMIT_RESET;
            r_char_count    <= '0;
            r_space_pending <= 1'b0;
            r_any_emitted   <= 1'b0;
            r_limit_reached <= 1'b0;
            r_seq_total     <= 3'd0;
            r_seq_have      <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                r_char_limit <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_char_count    <= n_char_count;
                r_space_pending <= n_space_pending;
                r_any_emitted   <= n_any_emitted;
                r_limit_reached <= n_limit_reached;
                r_seq_total     <= n_seq_total;
                r_seq_have      <= n_seq_have;
            end
        end
    end

    // sequence store: open-sequence bytes only, index never reaches 3
    always_ff @(posedge i_clk) begin
        if (i_accept && seq_wr && (r_seq_total == 3'd0)) begin
            r_seq_bytes[0] <= i_text_byte;
        end else if (i_accept && seq_wr && (r_seq_have[1:0] != 2'd3)) begin
            r_seq_bytes[r_seq_have[1:0]] <= i_text_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/upc_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 preview collapse job queue
// Small register queue decoupling the front end from the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module upc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire upc_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output upc_pkg::t_job      o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    upc_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/upc_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 preview collapse back end
// Serializes queued jobs into results via an output register, one per pop cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module upc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_empty,
    input  wire upc_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_present,
    output logic               o_text_done,
    output logic               o_run_last
);

    logic       r_valid;
    logic [2:0] r_pos;
    logic [7:0] r_byte;
    logic       r_present, r_done, r_last;

    logic       load, in_body;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign in_body = (r_pos < i_job.n);
    assign load    = !i_job_empty && (!r_valid || i_pop);

    always_comb begin
        if (in_body) begin
            cur_byte = i_job.bytes[r_pos[1:0]];
            cur_last = ((r_pos + 3'd1) == i_job.n) && !i_job.done;
        end else begin
            cur_byte = 8'h00;
            cur_last = 1'b1;
        end
    end

    assign o_job_pop = load && cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pos   <= cur_last ? 3'd0 : r_pos + 3'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= cur_byte;
            r_present <= in_body;
            r_done    <= !in_body;
            r_last    <= cur_last;
        end
    end

    assign o_empty        = !r_valid;
    assign o_out_byte     = r_byte;
    assign o_byte_present = r_present;
    assign o_text_done    = r_done;
    assign o_run_last     = r_last;

endmodule

`default_nettype wire

// ===== hdl/utf8_preview_whitespace_collapse_core.sv =====
// ----------------------------------------------------------------------------
// UTF-8 preview with whitespace collapse
// Takes text bytes through a push/full port and returns preview bytes, with
// collapsed whitespace and a character limit, through an empty/pop port.
//
// Input: one byte per transfer (push && !full), i_text_last on the final byte.
// Output: one result per transfer (pop && !empty); each text closes with an
// end marker (o_text_done, o_byte_present low), o_run_last marks the final
// result of each input byte that yields results.
// Config: i_cfg_we writes the 16-bit character limit; reset value 100.
// Path: a byte's job is first written into the job queue; its first result
// is then loaded from the queue head into the output register.
// Throughput: the front takes one byte per cycle while the job queue has
// room; the serializer delivers one result per cycle while the receiver
// pops, through the single output register.
// Reset clears all per-text state and empties the queue and the output register.
// When the receiver stalls, the output holds, the queue fills, and full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_preview_whitespace_collapse_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_text_last,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_present,
    output logic             o_text_done,
    output logic             o_run_last
);

    logic          accept;
    logic          job_valid, job_pop, q_full, q_empty;
    upc_pkg::t_job job, head;

    assign full   = q_full;
    assign accept = push && !q_full;

    upc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .i_text_last (i_text_last),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    upc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (job_pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    upc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_empty    (q_empty),
        .i_job          (head),
        .o_job_pop      (job_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_text_done    (o_text_done),
        .o_run_last     (o_run_last)
    );

endmodule

`default_nettype wire

// ===== bench/utf8_preview_whitespace_collapse_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 preview core testbench
// Streams texts through the push/full port and checks every preview byte and
// end marker against a cycle-free predictor kept in step with each transfer.
// A directed table covers the corner cases. Random texts follow: ASCII,
// whitespace runs, multi-byte sequences, cut sequences and noise, under
// changing character limits, random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_preview_whitespace_collapse_core_test;

    localparam int ITEM_TARGET   = 330;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DIR_ROWS      = 31;
    localparam int PRINT_CAP     = 50;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       done;
        logic       run_last;
    } t_preview_res;

    typedef enum logic {
        ROW_ITEM,
        ROW_LIMIT
    } t_row_kind;

    typedef struct packed {
        t_row_kind    kind;
        logic [15:0]  val;
        logic [7:0]   b;
        logic         last;
        logic         typed;
        t_preview_res res;
    } t_dir_row;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_MOSTLY
    } t_pop_style;

    localparam t_preview_res NO_RES   = '0;
    localparam t_preview_res END_MARK = '{8'h00, 1'b0, 1'b1, 1'b0};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_text_byte = '0;
    logic        i_text_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_present;
    logic        o_text_done;
    logic        o_run_last;

    // predictor state
    logic [15:0] lim_q = upc_pkg::LIMIT_RESET;
    logic [15:0] count_q = '0;
    logic        gap_pending = 1'b0;
    logic        started = 1'b0;
    logic        closed = 1'b0;
    logic [7:0]  pend_bytes [0:3] = '{default: 8'h00};
    logic [2:0]  pend_total = '0;
    logic [2:0]  pend_have = '0;

    t_preview_res step_res [0:4];
    int           step_n;
    t_preview_res preview_due [$];

    int  mismatches = 0;
    int  work_items = 0;
    int  results_seen = 0;
    int  limit_writes = 0;
    int  full_cycles = 0;
    int  cycles = 0;
    int  burst_left = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;

    utf8_preview_whitespace_collapse_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_text_byte    (i_text_byte),
        .i_text_last    (i_text_last),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_text_done    (o_text_done),
        .o_run_last     (o_run_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycles,
                     preview_due.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic emit(input logic [7:0] d, input logic p, input logic dn);
        step_res[step_n] = '{d, p, dn, 1'b0};
        step_n++;
    endtask

    task automatic predict_preview(input logic [7:0] c, input logic last);
        logic go;
        step_n = 0;
        if (pend_total != 0) begin
            if (pend_have < 4) pend_bytes[pend_have[1:0]] = c;
            pend_have = pend_have + 3'd1;
            if (pend_have >= pend_total) begin
                for (int j = 0; j < 4; j++) begin
                    if (j < pend_total) emit(pend_bytes[j], 1'b1, 1'b0);
                end
                count_q = count_q + 16'd1;
                started = 1'b1;
                pend_total = '0;
                pend_have = '0;
            end
        end else if (!closed && count_q >= lim_q) begin
            closed = 1'b1;
        end else if (!closed) begin
            if (c == upc_pkg::SPACE_BYTE || (c >= 8'h09 && c <= 8'h0D)) begin
                gap_pending = started;
            end else if (!(c < upc_pkg::SPACE_BYTE || c == upc_pkg::DEL_BYTE)) begin
                go = 1'b1;
                if (gap_pending) begin
                    if ({1'b0, count_q} + 17'd1 >= {1'b0, lim_q}) begin
                        closed = 1'b1;
                        go = 1'b0;
                    end else begin
                        emit(upc_pkg::SPACE_BYTE, 1'b1, 1'b0);
                        count_q = count_q + 16'd1;
                        gap_pending = 1'b0;
                        started = 1'b1;
                    end
                end
                if (go) begin
                    if (c < upc_pkg::ASCII_TOP) begin
                        emit(c, 1'b1, 1'b0);
                        count_q = count_q + 16'd1;
                        started = 1'b1;
                    end else begin
                        pend_bytes[0] = c;
                        pend_have = 3'd1;
                        casez (c)
                            8'b110?????: pend_total = 3'd2;
                            8'b1110????: pend_total = 3'd3;
                            default:     pend_total = 3'd4;
                        endcase
                    end
                end
            end
        end
        if (last) begin
            emit(8'h00, 1'b0, 1'b1);
            count_q = '0;
            gap_pending = 1'b0;
            started = 1'b0;
            closed = 1'b0;
            pend_bytes = '{default: 8'h00};
            pend_total = '0;
            pend_have = '0;
        end
        if (step_n > 0) step_res[step_n - 1].run_last = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input t_preview_res tres);
        t_preview_res fixed;
        int gap;
        if (!push) push <= 1'b1;
        i_text_byte <= b;
        i_text_last <= l;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        work_items++;
        predict_preview(b, l);
        if (typed) begin
            fixed = tres;
            fixed.run_last = 1'b1;
            preview_due.push_back(fixed);
        end else begin
            for (int k = 0; k < step_n; k++) preview_due.push_back(step_res[k]);
        end
        if (burst_left > 0) begin
            burst_left--;
        end else if (!steady) begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // drain everything in flight, including items that produce no result
    task automatic settle();
        if (push) push <= 1'b0;
        @(posedge i_clk);
        while (preview_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        lim_q = v;
        limit_writes++;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] body_byte();
        return ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                           : (8'h80 | 8'($urandom_range(0, 63)));
    endfunction

    // result side: pop pattern changes to a random style after a random run
    initial begin
        t_pop_style style;
        int left;
        style = POP_ALWAYS;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            if (left == 0) begin
                style = t_pop_style'($urandom_range(0, 3));
                left = $urandom_range(8, 64);
            end
            left--;
            case (style)
                POP_ALWAYS: pop <= 1'b1;
                POP_HALF:   pop <= 1'($urandom_range(0, 1));
                POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
                default:    pop <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_preview_res want;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (preview_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %02h p%0d d%0d r%0d",
                                          o_out_byte, o_byte_present, o_text_done,
                                          o_run_last));
            end else begin
                want = preview_due.pop_front();
                if (o_out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              o_out_byte, want.data));
                if (o_byte_present !== want.present)
                    report_mismatch($sformatf("byte_present %0d, want %0d",
                                              o_byte_present, want.present));
                if (o_text_done !== want.done)
                    report_mismatch($sformatf("text_done %0d, want %0d",
                                              o_text_done, want.done));
                if (o_run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %0d, want %0d",
                                              o_run_last, want.run_last));
            end
        end
        if (push && full) full_cycles++;
    end

    initial begin
        t_dir_row   rows [0:DIR_ROWS-1];
        logic [7:0] text_q [$];
        logic [15:0] lim_pick;
        int         n_chars;
        int         kind;
        int         text_idx;
        bit         noise;

        rows = '{
            '{ROW_ITEM,  16'd0,     8'h00, 1'b1, 1'b1, END_MARK},
            '{ROW_ITEM,  16'd0,     8'h20, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h41, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0}},
            '{ROW_ITEM,  16'd0,     8'h09, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h7F, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h42, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'hC3, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h0A, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'hF0, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h80, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h01, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'hFF, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h20, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'hE2, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h82, 1'b1, 1'b0, NO_RES},
            '{ROW_LIMIT, 16'd0,     8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h41, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'hFF, 1'b1, 1'b1, END_MARK},
            '{ROW_LIMIT, 16'd2,     8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h78, 1'b0, 1'b1, '{8'h78, 1'b1, 1'b0, 1'b0}},
            '{ROW_ITEM,  16'd0,     8'h20, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h79, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h7A, 1'b1, 1'b1, END_MARK},
            '{ROW_LIMIT, 16'd3,     8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h61, 1'b0, 1'b1, '{8'h61, 1'b1, 1'b0, 1'b0}},
            '{ROW_ITEM,  16'd0,     8'h20, 1'b0, 1'b0, NO_RES},
            '{ROW_LIMIT, 16'hFFFF,  8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'hBF, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h20, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h00, 1'b0, 1'b0, NO_RES},
            '{ROW_ITEM,  16'd0,     8'h80, 1'b1, 1'b0, NO_RES}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_LIMIT) begin
                settle();
                write_limit(rows[r].val);
            end else begin
                send_byte(rows[r].b, rows[r].last, rows[r].typed, rows[r].res);
            end
        end

        text_idx = 0;
        while (work_items < ITEM_TARGET) begin
            if (text_idx % 4 == 0) begin
                settle();
                case ($urandom_range(0, 7))
                    0:       lim_pick = 16'd0;
                    1:       lim_pick = 16'd1;
                    2:       lim_pick = 16'd2;
                    3, 4:    lim_pick = 16'($urandom_range(3, 16));
                    5:       lim_pick = upc_pkg::LIMIT_RESET;
                    6:       lim_pick = 16'($urandom);
                    default: lim_pick = 16'hFFFF;
                endcase
                // the long-stall text needs room for every character
                if (text_idx == 8) lim_pick = 16'hFFFF;
                write_limit(lim_pick);
            end
            if (text_idx == 8) begin
                hold_req = 1'b1;
                steady = 1'b1;
            end

            text_q.delete();
            noise = ($urandom_range(0, 6) == 0) && (text_idx != 8);
            n_chars = (text_idx == 8) ? 30 : $urandom_range(0, 12);
            for (int i = 0; i < n_chars; i++) begin
                kind = (text_idx == 8) ? 0 : (noise ? 9 : $urandom_range(0, 9));
                case (kind)
                    0, 1, 2, 3: text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    4: repeat ($urandom_range(1, 3))
                           text_q.push_back($urandom_range(0, 1) ? upc_pkg::SPACE_BYTE
                                            : 8'($urandom_range(8'h09, 8'h0D)));
                    5: text_q.push_back(($urandom_range(0, 5) == 0) ? upc_pkg::DEL_BYTE
                                        : 8'($urandom_range(0, 8'h1F)));
                    6: begin
                        text_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                        text_q.push_back(body_byte());
                    end
                    7: begin
                        text_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                        repeat (2) text_q.push_back(body_byte());
                    end
                    8: begin
                        // stray continuation bytes also open a four-byte run
                        text_q.push_back(($urandom_range(0, 3) == 0)
                                         ? 8'($urandom_range(8'h80, 8'hBF))
                                         : 8'($urandom_range(8'hF0, 8'hFF)));
                        repeat (3) text_q.push_back(body_byte());
                    end
                    default: text_q.push_back(8'($urandom));
                endcase
            end
            if ($urandom_range(0, 4) == 0 && text_q.size() > 1) void'(text_q.pop_back());
            if (text_q.size() == 0) text_q.push_back(8'($urandom));

            foreach (text_q[i])
                send_byte(text_q[i], (i == text_q.size() - 1), 1'b0, NO_RES);
            steady = 1'b0;
            text_idx++;
        end

        settle();
        $display("Sent %0d input bytes, with %0d random texts after the directed table,",
                 work_items, text_idx);
        $display("%0d results checked, %0d limit writes, %0d cycles with input full",
                 results_seen, limit_writes, full_cycles);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
